FILE: design/pfsc_pkg.sv
// Package for the pixel format screen converter: payload structs, register
// indexes, format codes and the control structs of the phase calculator.
// No dependencies.
package pfsc_pkg;

	localparam int COUNT_W   = 16;  // column and row counters
	localparam int GROUP_W   = 5;   // zoom + 1, up to 16
	localparam int PHASE_W   = 4;   // position inside a decimation group
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SRC_INDEX_ENTRIES = 256;  // codes of an 8-bit source index

	typedef enum logic [1:0] {
		OP_PIXEL     = 2'd0,
		OP_PAL_WRITE = 2'd1,
		OP_FRAME     = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_FORMAT = 3'd0,
		REG_TARGET_MODE   = 3'd1,
		REG_BYTE_SWAP     = 3'd2,
		REG_PACK_LAYOUT   = 3'd3,
		REG_ZOOM          = 3'd4,
		REG_IMAGE_WIDTH   = 3'd5,
		REG_IMAGE_HEIGHT  = 3'd6
	} cfg_reg_t;

	localparam logic [1:0] SRC_PALETTE = 2'd0;
	localparam logic [1:0] SRC_RGB565  = 2'd1;

	localparam logic [1:0] TGT_PACK16    = 2'd0;
	localparam logic [1:0] TGT_RGB24     = 2'd1;
	localparam logic [1:0] TGT_PAD_FIRST = 2'd2;
	localparam logic [1:0] TGT_PAD_LAST  = 2'd3;

	localparam logic [1:0] LAYOUT_555    = 2'd0;
	localparam logic [1:0] LAYOUT_565_G5 = 2'd2;

	localparam logic [7:0]  MASK_5BIT  = 8'hf8;
	localparam logic [7:0]  MASK_6BIT  = 8'hfc;
	localparam logic [15:0] MASK_R565  = 16'hf800;
	localparam logic [15:0] MASK_G565  = 16'h07e0;
	localparam logic [15:0] MASK_B565  = 16'h001f;

	localparam logic [2:0] BYTES_16 = 3'd2;
	localparam logic [2:0] BYTES_24 = 3'd3;
	localparam logic [2:0] BYTES_32 = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [23:0] pixel_value;
		logic [7:0]  palette_index;
		logic [23:0] palette_color;
	} pix_in_t;

	typedef struct packed {
		logic [31:0] screen_word;
		logic [2:0]  byte_count;
		logic        row_end;
	} pix_out_t;

	typedef struct packed {
		logic               start;
		logic [GROUP_W-1:0] divisor;
	} phase_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [PHASE_W-1:0] col_phase;
		logic [PHASE_W-1:0] row_phase;
	} phase_rsp_t;

endpackage

FILE: design/pfsc_phase_calc.sv
// Phase calculator: column and row counter modulo the decimation group size,
// one restoring remainder bit per cycle for both counters in parallel.
// Depends on pfsc_pkg.
module pfsc_phase_calc (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfsc_pkg::phase_req_t             req,
	input  logic [pfsc_pkg::COUNT_W-1:0]     col,
	input  logic [pfsc_pkg::COUNT_W-1:0]     row,
	output pfsc_pkg::phase_rsp_t             rsp
);
	import pfsc_pkg::*;

	localparam int STEP_W = $clog2(COUNT_W);

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [GROUP_W-1:0]  divisor_q;
	logic [COUNT_W-1:0]  col_sh_q;
	logic [COUNT_W-1:0]  row_sh_q;
	logic [PHASE_W-1:0]  col_rem_q;
	logic [PHASE_W-1:0]  row_rem_q;
	logic [GROUP_W-1:0]  col_trial;
	logic [GROUP_W-1:0]  row_trial;
	logic [PHASE_W-1:0]  col_rem_d;
	logic [PHASE_W-1:0]  row_rem_d;
	logic                last_step;

	always_comb begin
		col_trial = {col_rem_q, col_sh_q[COUNT_W-1]};
		row_trial = {row_rem_q, row_sh_q[COUNT_W-1]};
		// subtract the divisor where it fits; the remainder stays below it
		col_rem_d = (col_trial >= divisor_q) ? PHASE_W'(col_trial - divisor_q)
		                                     : PHASE_W'(col_trial);
		row_rem_d = (row_trial >= divisor_q) ? PHASE_W'(row_trial - divisor_q)
		                                     : PHASE_W'(row_trial);
		last_step = (step_q == STEP_W'(COUNT_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			col_sh_q  <= col;
			row_sh_q  <= row;
			col_rem_q <= '0;
			row_rem_q <= '0;
		end else if (busy_q) begin
			col_sh_q  <= {col_sh_q[COUNT_W-2:0], 1'b0};
			row_sh_q  <= {row_sh_q[COUNT_W-2:0], 1'b0};
			col_rem_q <= col_rem_d;
			row_rem_q <= row_rem_d;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = busy_q && last_step;
	assign rsp.col_phase = col_rem_d;
	assign rsp.row_phase = row_rem_d;

endmodule

FILE: design/pixel_format_screen_converter.sv
// Pixel format screen converter top level: counters, decimation, palette
// memory and conversion to 16, 24 or 32-bit screen words.
// Depends on pfsc_pkg and pfsc_phase_calc.
//
//   channel  handshake             payload
//   in       in_valid / in_stall    in_data  (pfsc_pkg::pix_in_t)
//   out      out_valid / out_stall  out_data (pfsc_pkg::pix_out_t)
//   config   cfg_wr_en              cfg_addr, cfg_wdata
//
// One item per clock while in_stall is low. A kept pixel takes the palette
// read and decimation decision in the first stage and the format conversion
// into the output register in the second, from which it appears on out.
// A write of zoom stalls the input while the phase calculator derives the
// counters' positions in the new group size, one bit per cycle.
// Reset restores the register defaults and clears the counters; the palette
// holds no defined value until written and has no clearing pass.
// out_stall holds the output register; the input stalls when both stages hold
// a pixel and out_stall is high, and while the phase calculator is busy.
module pixel_format_screen_converter #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  pfsc_pkg::pix_in_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output pfsc_pkg::pix_out_t                   out_data,
	input  logic                                 cfg_wr_en,
	input  logic [pfsc_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [pfsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import pfsc_pkg::*;

	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// configuration
	logic [1:0]          source_format_q;
	logic [1:0]          target_mode_q;
	logic                byte_swap_q;
	logic [1:0]          pack_layout_q;
	logic [PHASE_W-1:0]  zoom_q;
	logic [COUNT_W-1:0]  image_width_q;
	logic [COUNT_W-1:0]  image_height_q;

	// counters and their positions inside the decimation group
	logic [COUNT_W-1:0]  col_q;
	logic [COUNT_W-1:0]  row_q;
	logic [PHASE_W-1:0]  col_phase_q;
	logic [PHASE_W-1:0]  row_phase_q;

	logic [23:0]         pal_mem [PALETTE_ENTRIES];
	logic [IDX_W-1:0]    pal_idx_map [SRC_INDEX_ENTRIES];
	logic [7:0]          idx_sel;
	logic [IDX_W-1:0]    pal_addr;

	phase_req_t          phase_req;
	phase_rsp_t          phase_rsp;

	logic                in_xfer;
	logic                is_pixel;
	logic [GROUP_W-1:0]  group;
	logic [COUNT_W:0]    col_inc;
	logic [COUNT_W:0]    row_inc;
	logic                col_wrap;
	logic                row_wrap;
	logic                kept;
	logic                last;

	logic                valid_s1;
	logic [23:0]         pv_s1;
	logic                last_s1;
	logic [23:0]         pal_s1;
	logic                adv_s1;
	logic                valid_s2;
	pix_out_t            data_s2;

	function automatic pix_out_t convert(
		input logic [23:0] pv,
		input logic [23:0] pal,
		input logic [1:0]  fmt,
		input logic [1:0]  tgt,
		input logic        swap,
		input logic [1:0]  layout,
		input logic        row_end
	);
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [15:0] w16;
		logic [15:0] r16;
		logic [15:0] g16;
		logic [7:0]  c0;
		logic [7:0]  c2;
		pix_out_t    res;
		case (fmt)
			SRC_PALETTE: begin
				r = pal[23:16];
				g = pal[15:8];
				b = pal[7:0];
			end
			SRC_RGB565: begin
				r = 8'((pv[15:0] & MASK_R565) >> 8);
				g = 8'((pv[15:0] & MASK_G565) >> 3);
				b = {pv[4:0] & MASK_B565[4:0], 3'b000};
			end
			default: begin
				r = pv[23:16];
				g = pv[15:8];
				b = pv[7:0];
			end
		endcase
		case (layout)
			LAYOUT_555: begin
				r16 = 16'(r & MASK_5BIT) << 7;
				g16 = 16'(g & MASK_5BIT) << 2;
			end
			LAYOUT_565_G5: begin
				r16 = 16'(r & MASK_5BIT) << 8;
				g16 = 16'(g & MASK_5BIT) << 3;
			end
			default: begin
				r16 = 16'(r & MASK_5BIT) << 8;
				g16 = 16'(g & MASK_6BIT) << 3;
			end
		endcase
		w16 = r16 | g16 | 16'(b >> 3);
		if (swap) begin
			w16 = {w16[7:0], w16[15:8]};
		end
		c0 = swap ? b : r;
		c2 = swap ? r : b;
		res.row_end = row_end;
		case (tgt)
			TGT_PACK16: begin
				// an unswapped RGB565 source already in an 8/3 layout passes through
				if (fmt == SRC_RGB565 && layout != LAYOUT_555 && !swap) begin
					res.screen_word = {16'h0000, pv[15:0]};
				end else begin
					res.screen_word = {16'h0000, w16};
				end
				res.byte_count = BYTES_16;
			end
			TGT_RGB24: begin
				res.screen_word = {8'h00, c0, g, c2};
				res.byte_count  = BYTES_24;
			end
			TGT_PAD_FIRST: begin
				res.screen_word = {8'h00, c0, g, c2};
				res.byte_count  = BYTES_32;
			end
			default: begin
				res.screen_word = {c0, g, c2, 8'h00};
				res.byte_count  = BYTES_32;
			end
		endcase
		return res;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= 2'd0;
			target_mode_q   <= 2'd0;
			byte_swap_q     <= 1'b0;
			pack_layout_q   <= 2'd1;
			zoom_q          <= '0;
			image_width_q   <= 16'd640;
			image_height_q  <= 16'd480;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_SOURCE_FORMAT: source_format_q <= cfg_wdata[1:0];
				REG_TARGET_MODE:   target_mode_q   <= cfg_wdata[1:0];
				REG_BYTE_SWAP:     byte_swap_q     <= cfg_wdata[0];
				REG_PACK_LAYOUT:   pack_layout_q   <= cfg_wdata[1:0];
				REG_ZOOM:          zoom_q          <= cfg_wdata[PHASE_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_wdata;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// new group size: recompute where the counters sit inside a group
	assign phase_req.start   = cfg_wr_en && (cfg_addr == REG_ZOOM);
	assign phase_req.divisor = GROUP_W'(cfg_wdata[PHASE_W-1:0]) + GROUP_W'(1);

	pfsc_phase_calc u_phase_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (phase_req),
		.col    (col_q),
		.row    (row_q),
		.rsp    (phase_rsp)
	);

	// palette index folded onto the palette depth
	for (genvar i = 0; i < SRC_INDEX_ENTRIES; i++) begin : g_idx_map
		assign pal_idx_map[i] = IDX_W'(i % PALETTE_ENTRIES);
	end

	assign in_xfer  = in_valid && !in_stall;
	assign is_pixel = (in_data.op == OP_PIXEL);
	assign idx_sel  = (in_data.op == OP_PAL_WRITE) ? in_data.palette_index
	                                               : in_data.pixel_value[7:0];
	assign pal_addr = pal_idx_map[idx_sel];

	always_comb begin
		group    = GROUP_W'(zoom_q) + GROUP_W'(1);
		col_inc  = {1'b0, col_q} + (COUNT_W+1)'(1);
		row_inc  = {1'b0, row_q} + (COUNT_W+1)'(1);
		col_wrap = (col_inc >= {1'b0, image_width_q});
		row_wrap = (row_inc >= {1'b0, image_height_q});
		// kept: first of a group that fits completely inside the image
		kept = (col_phase_q == '0) && (row_phase_q == '0)
		    && (({1'b0, col_q} + (COUNT_W+1)'(group)) <= {1'b0, image_width_q})
		    && (({1'b0, row_q} + (COUNT_W+1)'(group)) <= {1'b0, image_height_q});
		// last: the group after this one no longer fits
		last = (({1'b0, col_q} + (COUNT_W+1)'({group, 1'b0}))
		        > {1'b0, image_width_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
		end else if (phase_rsp.done) begin
			col_phase_q <= phase_rsp.col_phase;
			row_phase_q <= phase_rsp.row_phase;
		end else if (in_xfer) begin
			case (in_data.op)
				OP_FRAME: begin
					col_q       <= '0;
					row_q       <= '0;
					col_phase_q <= '0;
					row_phase_q <= '0;
				end
				OP_PIXEL: begin
					if (col_wrap) begin
						col_q       <= '0;
						col_phase_q <= '0;
						if (row_wrap) begin
							row_q       <= '0;
							row_phase_q <= '0;
						end else begin
							row_q       <= row_inc[COUNT_W-1:0];
							row_phase_q <= (row_phase_q == zoom_q) ? '0
							             : row_phase_q + PHASE_W'(1);
						end
					end else begin
						col_q       <= col_inc[COUNT_W-1:0];
						col_phase_q <= (col_phase_q == zoom_q) ? '0
						             : col_phase_q + PHASE_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_data.op == OP_PAL_WRITE) begin
			pal_mem[pal_addr] <= in_data.palette_color;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && is_pixel) begin
			pal_s1 <= pal_mem[pal_addr];
		end
	end

	// stage 1 advances whenever the output register is free or being taken
	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = phase_rsp.busy || (valid_s1 && !adv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer && is_pixel && kept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && is_pixel) begin
			pv_s1   <= in_data.pixel_value;
			last_s1 <= last;
		end
		if (adv_s1 && valid_s1) begin
			data_s2 <= convert(pv_s1, pal_s1, source_format_q, target_mode_q,
			                   byte_swap_q, pack_layout_q, last_s1);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

`ifndef NO_ASSERTIONS
	a_stall_while_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		phase_rsp.busy |-> in_stall)
		else $error("input open while phase calculator busy");

	a_phase_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!phase_rsp.busy |-> (col_phase_q <= zoom_q) && (row_phase_q <= zoom_q))
		else $error("counter phase outside decimation group");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("stage 1 pixel lost under stall");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.byte_count == BYTES_16)
		           || (out_data.byte_count == BYTES_24)
		           || (out_data.byte_count == BYTES_32))
		else $error("bad byte count");

	a_word16_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_count == BYTES_16
		|-> out_data.screen_word[31:16] == 16'h0000)
		else $error("16-bit word with upper bytes set");
`endif

endmodule

FILE: bench/pixel_format_screen_converter_test.sv
`timescale 1ns / 1ps
// Testbench for pixel_format_screen_converter: a directed table, then random
// phases over many register settings, each checked against a pixel predictor.
// Depends on pfsc_pkg and the converter RTL.
module pixel_format_screen_converter_test;

	import pfsc_pkg::*;

	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 24;   // pipeline depth plus the zoom recalculation
	localparam int PHASES        = 18;
	localparam int PHASE_ITEMS   = 85;
	localparam int MAX_REPORTS   = 10;
	localparam longint TIMEOUT_NS = 4_000_000;

	// Codes that the package leaves without a name
	localparam logic [1:0] OP_IGNORED   = 2'd3;
	localparam logic [1:0] SRC_RGB888   = 2'd2;
	localparam logic [1:0] SRC_UNUSED   = 2'd3;
	localparam logic [1:0] LAYOUT_565   = 2'd1;
	localparam logic [1:0] LAYOUT_UNUSED = 2'd3;

	localparam cfg_reg_t WRITE_ORDER [7] = '{REG_SOURCE_FORMAT, REG_TARGET_MODE,
		REG_BYTE_SWAP, REG_PACK_LAYOUT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_ZOOM};

	typedef struct {
		bit          is_cfg;
		cfg_reg_t    reg_idx;
		logic [15:0] reg_val;
		pix_in_t     item;
		bit          pinned;
		bit          pin_has;
		pix_out_t    pin_out;
	} step_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	pix_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pix_out_t              out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned fault_count   = 0;

	pix_out_t screen_words_due [$];
	pix_out_t want;

	// Predictor state
	logic [1:0]  cfg_source = SRC_PALETTE;
	logic [1:0]  cfg_target = TGT_PACK16;
	logic        cfg_swap   = 1'b0;
	logic [1:0]  cfg_layout = LAYOUT_565;
	logic [3:0]  cfg_zoom   = 4'd0;
	logic [15:0] cfg_width  = 16'd640;
	logic [15:0] cfg_height = 16'd480;
	logic [15:0] col_pos    = '0;
	logic [15:0] row_pos    = '0;
	logic [23:0] palette_copy [256];
	bit          pal_written  [256];
	logic [7:0]  pal_written_list [$];

	pixel_format_screen_converter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("pixel_format_screen_converter_test: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Advance the counters and work out the screen word of one input item
	function automatic bit convert_pixel(input pix_in_t it, output pix_out_t res);
		int unsigned col, row, group, kw, kh;
		logic [23:0] pv, entry;
		logic [7:0]  r, g, b, c0, c2;
		logic [15:0] w16;
		res = '0;
		pv = it.pixel_value;
		if (it.op == OP_PAL_WRITE) begin
			palette_copy[it.palette_index] = it.palette_color;
			return 1'b0;
		end
		if (it.op == OP_FRAME) begin
			col_pos = '0;
			row_pos = '0;
			return 1'b0;
		end
		if (it.op != OP_PIXEL)
			return 1'b0;

		col = col_pos;
		row = row_pos;
		if (col + 1 >= cfg_width) begin
			col_pos = '0;
			row_pos = (row + 1 >= cfg_height) ? 16'd0 : 16'(row + 1);
		end else begin
			col_pos = 16'(col + 1);
		end

		group = cfg_zoom + 1;
		kw = (cfg_width / group) * group;
		kh = (cfg_height / group) * group;
		if (!(col < kw && row < kh && col % group == 0 && row % group == 0))
			return 1'b0;

		case (cfg_source)
			SRC_PALETTE: entry = palette_copy[pv[7:0]];
			SRC_RGB565:  entry = {pv[15:11], 3'b000, pv[10:5], 2'b00, pv[4:0], 3'b000};
			default:     entry = pv;
		endcase
		r = entry[23:16];
		g = entry[15:8];
		b = entry[7:0];

		if (cfg_target == TGT_PACK16) begin
			if (cfg_source == SRC_RGB565 && cfg_layout != LAYOUT_555 && !cfg_swap) begin
				w16 = pv[15:0];
			end else begin
				case (cfg_layout)
					LAYOUT_555:    w16 = {1'b0, r[7:3], g[7:3], b[7:3]};
					LAYOUT_565_G5: w16 = {r[7:3], g[7:3], 1'b0, b[7:3]};
					default:       w16 = {r[7:3], g[7:2], b[7:3]};
				endcase
				if (cfg_swap)
					w16 = {w16[7:0], w16[15:8]};
			end
			res.screen_word = {16'h0000, w16};
			res.byte_count  = BYTES_16;
		end else begin
			c0 = cfg_swap ? b : r;
			c2 = cfg_swap ? r : b;
			res.screen_word = {8'h00, c0, g, c2};
			res.byte_count  = BYTES_24;
			if (cfg_target == TGT_PAD_FIRST) begin
				res.byte_count = BYTES_32;
			end else if (cfg_target == TGT_PAD_LAST) begin
				res.screen_word = {c0, g, c2, 8'h00};
				res.byte_count  = BYTES_32;
			end
		end
		res.row_end = (col + group >= kw);
		return 1'b1;
	endfunction

	task automatic push_item(input pix_in_t it, input bit pinned, input bit pin_has,
		input pix_out_t pin_out);
		pix_out_t predicted;
		bit has;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.op == OP_PAL_WRITE && !pal_written[it.palette_index]) begin
			pal_written[it.palette_index] = 1'b1;
			pal_written_list.push_back(it.palette_index);
		end
		has = convert_pixel(it, predicted);
		if (pinned) begin
			has = pin_has;
			predicted = pin_out;
		end
		if (has)
			screen_words_due.push_back(predicted);
	endtask

	// Hold off until every result is out and dropped items have left the pipeline
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (screen_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SOURCE_FORMAT: cfg_source = val[1:0];
			REG_TARGET_MODE:   cfg_target = val[1:0];
			REG_BYTE_SWAP:     cfg_swap   = val[0];
			REG_PACK_LAYOUT:   cfg_layout = val[1:0];
			REG_ZOOM:          cfg_zoom   = val[3:0];
			REG_IMAGE_WIDTH:   cfg_width  = val;
			REG_IMAGE_HEIGHT:  cfg_height = val;
			default: ;
		endcase
	endtask

	function automatic step_row_t row_cfg(input cfg_reg_t idx, input logic [15:0] val);
		step_row_t r;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		r.item    = '0;
		r.pinned  = 1'b0;
		r.pin_has = 1'b0;
		r.pin_out = '0;
		return r;
	endfunction

	function automatic step_row_t row_item(input logic [1:0] op, input logic [23:0] pv,
		input logic [7:0] idx, input logic [23:0] color);
		step_row_t r;
		r.is_cfg  = 1'b0;
		r.reg_idx = REG_SOURCE_FORMAT;
		r.reg_val = '0;
		r.item.op            = op;
		r.item.pixel_value   = pv;
		r.item.palette_index = idx;
		r.item.palette_color = color;
		r.pinned  = 1'b0;
		r.pin_has = 1'b0;
		r.pin_out = '0;
		return r;
	endfunction

	function automatic step_row_t row_pin(input step_row_t r, input bit has,
		input logic [31:0] word, input logic [2:0] count, input logic last);
		r.pinned  = 1'b1;
		r.pin_has = has;
		r.pin_out.screen_word = word;
		r.pin_out.byte_count  = count;
		r.pin_out.row_end     = last;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (screen_words_due.size() == 0) begin
				if (fault_count < MAX_REPORTS)
					$display("%0t: unexpected screen word %h bytes %0d row_end %0d", $time,
						out_data.screen_word, out_data.byte_count, out_data.row_end);
				fault_count++;
			end else begin
				want = screen_words_due.pop_front();
				if (out_data.screen_word !== want.screen_word ||
						out_data.byte_count !== want.byte_count ||
						out_data.row_end !== want.row_end) begin
					if (fault_count < MAX_REPORTS)
						$display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d", $time,
							want.screen_word, want.byte_count, want.row_end,
							out_data.screen_word, out_data.byte_count, out_data.row_end);
					fault_count++;
				end
			end
		end
	end

	initial begin
		step_row_t   directed [$];
		logic [15:0] setting [7];
		pix_in_t     item;
		int unsigned pick, zoom_pick;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: palette source, 565 packing
		directed.push_back(row_pin(row_item(OP_PAL_WRITE, 24'h000000, 8'h00, 24'h000000),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_PAL_WRITE, 24'h000000, 8'hff, 24'hffffff),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_PAL_WRITE, 24'h000000, 8'h5a, 24'h123456),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'hffff00, 8'h00, 24'h000000),
			1'b1, 32'h0000_0000, BYTES_16, 1'b0));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'h0000ff, 8'hff, 24'hffffff),
			1'b1, 32'h0000_ffff, BYTES_16, 1'b0));
		directed.push_back(row_item(OP_PIXEL, 24'h00005a, 8'h00, 24'h000000));
		directed.push_back(row_pin(row_item(OP_FRAME, 24'h00005a, 8'h33, 24'h0f0f0f),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_IGNORED, 24'h00005a, 8'hcc, 24'hf0f0f0),
			1'b0, '0, '0, 1'b0));
		// Passthrough of a 565 source
		directed.push_back(row_cfg(REG_SOURCE_FORMAT, SRC_RGB565));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'hffa5c3, 8'h00, 24'h000000),
			1'b1, 32'h0000_a5c3, BYTES_16, 1'b0));
		directed.push_back(row_cfg(REG_PACK_LAYOUT, LAYOUT_565_G5));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'h00ffff, 8'h00, 24'h000000),
			1'b1, 32'h0000_ffff, BYTES_16, 1'b0));
		directed.push_back(row_cfg(REG_BYTE_SWAP, 16'd1));
		directed.push_back(row_item(OP_PIXEL, 24'h00f81f, 8'h00, 24'h000000));
		// Byte targets, pad byte zero
		directed.push_back(row_cfg(REG_SOURCE_FORMAT, SRC_RGB888));
		directed.push_back(row_cfg(REG_TARGET_MODE, TGT_PAD_LAST));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'hffffff, 8'h00, 24'h000000),
			1'b1, 32'hffff_ff00, BYTES_32, 1'b0));
		directed.push_back(row_cfg(REG_TARGET_MODE, TGT_PAD_FIRST));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'h123456, 8'h00, 24'h000000),
			1'b1, 32'h0056_3412, BYTES_32, 1'b0));
		directed.push_back(row_cfg(REG_TARGET_MODE, TGT_RGB24));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'h000000, 8'h00, 24'h000000),
			1'b1, 32'h0000_0000, BYTES_24, 1'b0));
		// One-pixel frame: every pixel ends a row and wraps the counters
		directed.push_back(row_cfg(REG_IMAGE_WIDTH, 16'd1));
		directed.push_back(row_cfg(REG_IMAGE_HEIGHT, 16'd1));
		directed.push_back(row_pin(row_item(OP_FRAME, 24'h000000, 8'h00, 24'h000000),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'habcdef, 8'h00, 24'h000000),
			1'b1, 32'h00ef_cdab, BYTES_24, 1'b1));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'h000001, 8'h00, 24'h000000),
			1'b1, 32'h0001_0000, BYTES_24, 1'b1));
		// Zero width keeps nothing
		directed.push_back(row_cfg(REG_IMAGE_WIDTH, 16'd0));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'hffffff, 8'h00, 24'h000000),
			1'b0, '0, '0, 1'b0));
		// Partial groups at the right and bottom edges drop out
		directed.push_back(row_cfg(REG_IMAGE_WIDTH, 16'd3));
		directed.push_back(row_cfg(REG_IMAGE_HEIGHT, 16'd3));
		directed.push_back(row_cfg(REG_ZOOM, 16'd1));
		directed.push_back(row_pin(row_item(OP_FRAME, 24'h000000, 8'h00, 24'h000000),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'h102030, 8'h00, 24'h000000),
			1'b1, 32'h0030_2010, BYTES_24, 1'b1));
		directed.push_back(row_item(OP_PIXEL, 24'h445566, 8'h00, 24'h000000));
		directed.push_back(row_item(OP_PIXEL, 24'h778899, 8'h00, 24'h000000));
		directed.push_back(row_item(OP_PIXEL, 24'haabbcc, 8'h00, 24'h000000));
		// Unused source format and layout codes
		directed.push_back(row_cfg(REG_SOURCE_FORMAT, SRC_UNUSED));
		directed.push_back(row_cfg(REG_PACK_LAYOUT, LAYOUT_UNUSED));
		directed.push_back(row_cfg(REG_TARGET_MODE, TGT_PACK16));
		directed.push_back(row_cfg(REG_BYTE_SWAP, 16'd0));
		directed.push_back(row_cfg(REG_ZOOM, 16'd0));
		directed.push_back(row_pin(row_item(OP_FRAME, 24'h000000, 8'h00, 24'h000000),
			1'b0, '0, '0, 1'b0));
		directed.push_back(row_pin(row_item(OP_PIXEL, 24'hffffff, 8'h00, 24'h000000),
			1'b1, 32'h0000_ffff, BYTES_16, 1'b0));

		foreach (directed[k]) begin
			if (directed[k].is_cfg) begin
				drain_and_settle();
				write_reg(directed[k].reg_idx, directed[k].reg_val);
				cfg_wr_en <= 1'b0;
			end else begin
				push_item(directed[k].item, directed[k].pinned, directed[k].pin_has,
					directed[k].pin_out);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			// Index order: source, target, swap, layout, zoom, width, height
			case (p)
				0: setting = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd8, 16'd6};
				1: setting = '{16'd1, 16'd0, 16'd0, 16'd2, 16'd0, 16'd5, 16'd4};
				2: setting = '{16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd7, 16'd5};
				3: setting = '{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4, 16'd4};
				4: setting = '{16'd2, 16'd1, 16'd0, 16'd1, 16'd15, 16'd32, 16'd17};
				5: setting = '{16'd3, 16'd2, 16'd1, 16'd3, 16'd2, 16'd9, 16'd7};
				6: setting = '{16'd0, 16'd3, 16'd1, 16'd0, 16'd0, 16'd65535, 16'd65535};
				7: setting = '{16'd2, 16'd3, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
				8: setting = '{16'd1, 16'd1, 16'd0, 16'd1, 16'd3, 16'd1, 16'd65535};
				9: setting = '{16'd0, 16'd2, 16'd0, 16'd2, 16'd0, 16'd1, 16'd2};
				default: begin
					zoom_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
						: $urandom_range(0, 3);
					setting[REG_SOURCE_FORMAT] = 16'($urandom_range(0, 3));
					setting[REG_TARGET_MODE]   = 16'($urandom_range(0, 3));
					setting[REG_BYTE_SWAP]     = 16'($urandom_range(0, 1));
					setting[REG_PACK_LAYOUT]   = 16'($urandom_range(0, 3));
					setting[REG_ZOOM]          = 16'(zoom_pick);
					setting[REG_IMAGE_WIDTH]   = 16'((zoom_pick + 1) * $urandom_range(1, 4)
						+ $urandom_range(0, zoom_pick));
					setting[REG_IMAGE_HEIGHT]  = 16'((zoom_pick + 1) * $urandom_range(1, 3)
						+ $urandom_range(0, zoom_pick));
				end
			endcase

			drain_and_settle();
			// Zoom goes last: its write starts the phase recalculation
			foreach (WRITE_ORDER[k])
				write_reg(WRITE_ORDER[k], setting[WRITE_ORDER[k]]);
			cfg_wr_en <= 1'b0;

			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 75; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 75; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				item.pixel_value   = 24'($urandom);
				item.palette_index = 8'($urandom);
				item.palette_color = 24'($urandom);
				pick = $urandom_range(0, 99);
				if (i == 0 || pick < 3)
					item.op = OP_FRAME;
				else if (pick < 9)
					item.op = OP_PAL_WRITE;
				else if (pick < 12)
					item.op = OP_IGNORED;
				else
					item.op = OP_PIXEL;
				// Point palette reads at entries already loaded
				if (cfg_source == SRC_PALETTE && !pal_written[item.pixel_value[7:0]])
					item.pixel_value[7:0] =
						pal_written_list[$urandom_range(0, pal_written_list.size() - 1)];
				push_item(item, 1'b0, 1'b0, '0);
			end
		end

		drain_and_settle();
		if (fault_count == 0)
			$display("pixel_format_screen_converter_test: PASS");
		else
			$display("pixel_format_screen_converter_test: FAIL");
		$finish;
	end

endmodule

FILE: pixel_format_screen_converter.f
design/pfsc_pkg.sv
design/pfsc_phase_calc.sv
design/pixel_format_screen_converter.sv
bench/pixel_format_screen_converter_test.sv
